FILE: design/grayscale_plane_lcd_refresh_defines.svh
// Assertion macros shared by the grey-level LCD refresh design.
// No dependencies; included by files that carry concurrent assertions.
`ifndef GRAYSCALE_PLANE_LCD_REFRESH_DEFINES_SVH
`define GRAYSCALE_PLANE_LCD_REFRESH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GLPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GLPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/glpr_pkg.sv
// Package for the grey-level LCD refresh engine: geometry, command codes,
// item and control structs, and the subframe combine function. No dependencies.
package glpr_pkg;

    // Panel geometry
    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int POSITIONS   = COLUMNS + 3;
    localparam int POS_W       = $clog2(POSITIONS);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROWS        = PAGES * COLUMNS;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STORE_BYTES = 2 * ROWS;

    // Field widths
    localparam int ADDR_W = 11;
    localparam int BYTE_W = 8;

    // Controller command codes
    localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'hb0;
    localparam logic [BYTE_W-1:0] CMD_COL_LO = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_COL_HI = 8'h10;
    localparam logic [BYTE_W-1:0] NIBBLE     = 8'h0f;

    // Byte positions within a page
    localparam logic [POS_W-1:0]  POS_PAGE   = POS_W'(0);
    localparam logic [POS_W-1:0]  POS_COL_LO = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_COL_HI = POS_W'(2);
    localparam logic [POS_W-1:0]  FIRST_DATA = POS_W'(3);
    localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(POSITIONS - 1);
    localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(PAGES - 1);

    // Subframe codes
    localparam logic [1:0] PLANE_AND = 2'd0;
    localparam logic [1:0] PLANE_XOR = 2'd1;
    localparam logic [1:0] PLANE_OR  = 2'd2;

    // Input action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Column offset reset value
    localparam logic [BYTE_W-1:0] COL_OFFSET_RST = 8'd1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] spi_byte;
        logic              is_data;
        logic [1:0]        plane_index;
        logic              end_of_subframe;
    } t_out_item;

    // Sequencer view of the byte about to be sent
    typedef struct packed {
        logic [BYTE_W-1:0] cmd_byte;
        logic              is_data;
        logic [1:0]        plane;
        logic              last;
        logic [ROW_W-1:0]  row;
    } t_seq_info;

    // Access request to the frame store
    typedef struct packed {
        logic              wr_en;
        logic              wr_hi;
        logic [ROW_W-1:0]  wr_row;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
    } t_store_req;

    // Combine the two buffer bytes of a column for one subframe
    function automatic logic [BYTE_W-1:0] plane_byte(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [1:0]        plane
    );
        logic [BYTE_W-1:0] res;
        case (plane)
            PLANE_AND: res = b & (a ^ b);
            PLANE_XOR: res = a ^ b;
            default:   res = a | b;
        endcase
        return res;
    endfunction

endpackage

FILE: design/glpr_seq.sv
// Refresh sequencer: subframe, page and byte position counters, command
// byte and frame store row for the next byte. Depends on glpr_pkg.
module glpr_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [glpr_pkg::BYTE_W-1:0]  i_col_offset,
    output glpr_pkg::t_seq_info          o_info
);

    logic [1:0]                  r_plane, n_plane;
    logic [glpr_pkg::PAGE_W-1:0] r_page,  n_page;
    logic [glpr_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic [glpr_pkg::POS_W-1:0]  col;
    logic [31:0]                 row32;

    // Position walk: commands, then data, page by page, subframe by subframe
    always_comb begin
        n_plane = r_plane;
        n_page  = r_page;
        n_pos   = r_pos;
        if (i_advance) begin
            if (r_pos == glpr_pkg::LAST_POS) begin
                n_pos = '0;
                if (r_page == glpr_pkg::LAST_PAGE) begin
                    n_page = '0;
                    if (r_plane == glpr_pkg::PLANE_OR) begin
                        n_plane = glpr_pkg::PLANE_AND;
                    end else begin
                        n_plane = r_plane + 2'd1;
                    end
                end else begin
                    n_page = r_page + 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= glpr_pkg::PLANE_AND;
            r_page  <= '0;
            r_pos   <= '0;
        end else begin
            r_plane <= n_plane;
            r_page  <= n_page;
            r_pos   <= n_pos;
        end
    end

    // Column and store row of a data byte
    assign col   = r_pos - glpr_pkg::FIRST_DATA;
    assign row32 = 32'(r_page) * 32'(glpr_pkg::COLUMNS) + 32'(col);

    // Byte description for the current position
    always_comb begin
        o_info.plane   = r_plane;
        o_info.row     = row32[glpr_pkg::ROW_W-1:0];
        o_info.is_data = 1'b0;
        o_info.last    = 1'b0;
        case (r_pos)
            glpr_pkg::POS_PAGE: begin
                o_info.cmd_byte = glpr_pkg::CMD_PAGE | (8'(r_page) & glpr_pkg::NIBBLE);
            end
            glpr_pkg::POS_COL_LO: begin
                o_info.cmd_byte = glpr_pkg::CMD_COL_LO | (i_col_offset & glpr_pkg::NIBBLE);
            end
            glpr_pkg::POS_COL_HI: begin
                o_info.cmd_byte = glpr_pkg::CMD_COL_HI
                                | ((i_col_offset >> 4) & glpr_pkg::NIBBLE);
            end
            default: begin
                o_info.cmd_byte = '0;
                o_info.is_data  = 1'b1;
                o_info.last     = (r_pos == glpr_pkg::LAST_POS)
                               && (r_page == glpr_pkg::LAST_PAGE);
            end
        endcase
    end

endmodule

FILE: design/glpr_store.sv
// Frame store: two byte planes (even and odd buffer bytes) addressed by row,
// registered read, clearing pass after reset. Depends on glpr_pkg.
module glpr_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  glpr_pkg::t_store_req         i_req,
    output logic [glpr_pkg::BYTE_W-1:0]  o_a,
    output logic [glpr_pkg::BYTE_W-1:0]  o_b,
    output logic                         o_busy
);

    logic [glpr_pkg::BYTE_W-1:0] r_mem_a [glpr_pkg::ROWS];
    logic [glpr_pkg::BYTE_W-1:0] r_mem_b [glpr_pkg::ROWS];
    logic [glpr_pkg::BYTE_W-1:0] r_a, r_b;
    logic                        r_busy, n_busy;
    logic [glpr_pkg::ROW_W-1:0]  r_clr_row, n_clr_row;

    // Clearing pass walks every row once after reset
    always_comb begin
        n_busy    = r_busy;
        n_clr_row = r_clr_row;
        if (r_busy) begin
            n_clr_row = r_clr_row + 1'b1;
            if (r_clr_row == glpr_pkg::ROW_W'(glpr_pkg::ROWS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else begin
            r_busy    <= n_busy;
            r_clr_row <= n_clr_row;
        end
    end

    // Write port: clear or one byte into the selected plane
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem_a[r_clr_row] <= '0;
            r_mem_b[r_clr_row] <= '0;
        end else if (i_req.wr_en && !i_req.wr_hi) begin
            r_mem_a[i_req.wr_row] <= i_req.wr_data;
        end else if (i_req.wr_en) begin
            r_mem_b[i_req.wr_row] <= i_req.wr_data;
        end
    end

    // Read port, registered; data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_a <= r_mem_a[i_req.rd_row];
            r_b <= r_mem_b[i_req.rd_row];
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_busy = r_busy;

endmodule

FILE: design/grayscale_plane_lcd_refresh.sv
// A tick item passes through stage one and then the output register to its result.
// Throughput: one item per cycle while o_stall is low; writes give no result.
// The frame store read (one row per cycle while o_stall is low, registered) sets the pipeline depth.
// Reset clears counters and sets column offset to 1; then a clearing pass over
// all PAGES*COLUMNS rows (1024) zeroes the frame store with o_stall held high.
// Depends on glpr_pkg, glpr_seq, glpr_store and the defines header.
`include "grayscale_plane_lcd_refresh_defines.svh"

module grayscale_plane_lcd_refresh (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_valid,
    input  glpr_pkg::t_in_item           i_item,
    output logic                         o_stall,
    // result items
    output logic                         o_valid,
    output glpr_pkg::t_out_item          o_item,
    input  logic                         i_stall,
    // column offset register
    input  logic                         i_cfg_valid,
    input  logic [glpr_pkg::BYTE_W-1:0]  i_cfg_data,
    output logic                         o_cfg_ready
);

    logic                         r_col_offset_v;
    logic [glpr_pkg::BYTE_W-1:0]  r_col_offset;
    glpr_pkg::t_seq_info          seq_info;
    glpr_pkg::t_store_req         store_req;
    logic [glpr_pkg::BYTE_W-1:0]  mem_a, mem_b;
    logic                         store_busy;
    logic                         in_acc, tick_acc, wr_acc, ready_out;
    logic [31:0]                  wr_addr32;

    logic                         r_s1_v, n_s1_v;
    logic [glpr_pkg::BYTE_W-1:0]  r_s1_cmd;
    logic                         r_s1_is_data;
    logic [1:0]                   r_s1_plane;
    logic                         r_s1_last;

    logic                         r_out_v, n_out_v;
    glpr_pkg::t_out_item          r_out, n_out;

    // Config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_offset   <= glpr_pkg::COL_OFFSET_RST;
            r_col_offset_v <= 1'b0;
        end else begin
            r_col_offset_v <= i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_col_offset <= i_cfg_data;
            end
        end
    end

    // Handshake: stage one frees up when the output register can take its item
    assign ready_out = !r_out_v || !i_stall;
    assign o_stall   = store_busy || (r_s1_v && !ready_out);
    assign in_acc    = i_valid && !o_stall;
    assign tick_acc  = in_acc && (i_item.action == glpr_pkg::ACT_TICK);
    assign wr_acc    = in_acc && (i_item.action == glpr_pkg::ACT_WRITE);
    assign wr_addr32 = 32'(i_item.address);

    // Frame store requests
    always_comb begin
        store_req.wr_en   = wr_acc && (wr_addr32 < 32'(glpr_pkg::STORE_BYTES));
        store_req.wr_hi   = wr_addr32[0];
        store_req.wr_row  = wr_addr32[glpr_pkg::ROW_W:1];
        store_req.wr_data = i_item.write_data;
        store_req.rd_en   = tick_acc;
        store_req.rd_row  = seq_info.row;
    end

    glpr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (tick_acc),
        .i_col_offset (r_col_offset),
        .o_info       (seq_info)
    );

    glpr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_a     (mem_a),
        .o_b     (mem_b),
        .o_busy  (store_busy)
    );

    // Stage one: byte description alongside the store read
    assign n_s1_v = tick_acc || (r_s1_v && !ready_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_cmd     <= seq_info.cmd_byte;
            r_s1_is_data <= seq_info.is_data;
            r_s1_plane   <= seq_info.plane;
            r_s1_last    <= seq_info.last;
        end
    end

    // Output register: combine buffer bytes for data, pass commands through
    always_comb begin
        n_out_v               = ready_out ? r_s1_v : r_out_v;
        n_out.spi_byte        = r_s1_is_data
                              ? glpr_pkg::plane_byte(mem_a, mem_b, r_s1_plane)
                              : r_s1_cmd;
        n_out.is_data         = r_s1_is_data;
        n_out.plane_index     = r_s1_plane;
        n_out.end_of_subframe = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    // Checks
    `GLPR_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n,
        store_busy, !in_acc, "item accepted during frame store clear")
    `GLPR_ASSERT_NEXT(a_tick_reaches_s1, i_clk, i_rst_n,
        tick_acc, r_s1_v, "accepted tick lost before stage one")
    `GLPR_ASSERT_NEXT(a_s1_moves_out, i_clk, i_rst_n,
        r_s1_v && ready_out, r_out_v, "stage one item dropped on advance")
    `GLPR_ASSERT_NOW(a_last_is_data, i_clk, i_rst_n,
        r_out_v && r_out.end_of_subframe, r_out.is_data,
        "end of subframe flagged on a command byte")
    `GLPR_ASSERT_NEXT(a_cfg_seen, i_clk, i_rst_n,
        i_cfg_valid, r_col_offset_v, "config write strobe not tracked")

endmodule
